### design/dsd_pkg.sv
`timescale 1ns / 1ps

package dsd_pkg;

    localparam int DIG_W  = 4;
    localparam int REM_W  = 59;
    localparam int DIV_W  = 60;
    localparam int ACC_W  = 63;
    localparam int CNT_W  = 2;

    localparam logic [DIG_W-1:0] DIGIT_MAX = 4'd9;
    localparam logic [DIV_W-1:0] DIV_ONE   = 60'd1;
    localparam logic [DIV_W-1:0] DIV_MAX   = 60'h800_0000_0000_0000;
    localparam logic [CNT_W-1:0] STEP_TOP  = 2'd3;

    typedef struct packed {
        logic [DIG_W-1:0] digit;
        logic             first_digit;
        logic             last_digit;
    } t_dsd_in;

    typedef struct packed {
        logic [DIG_W-1:0] quotient_digit;
        logic             quotient_valid;
        logic [REM_W-1:0] remainder;
        logic             is_last;
    } t_dsd_out;

    typedef struct packed {
        logic             load;
        logic             step;
        logic [CNT_W-1:0] shift;
    } t_dsd_ctrl;

endpackage

### design/dsd_datapath.sv
`timescale 1ns / 1ps

module dsd_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dsd_pkg::t_dsd_ctrl            i_ctrl,
    input  dsd_pkg::t_dsd_in              i_in_data,
    input  logic                          i_cfg_we,
    input  logic [dsd_pkg::DIV_W-1:0]     i_cfg_data,
    output logic [dsd_pkg::DIG_W-1:0]     o_q_next,
    output logic [dsd_pkg::REM_W-1:0]     o_rem_next
);

    logic [dsd_pkg::DIV_W-1:0] r_div;
    logic [dsd_pkg::DIV_W-1:0] n_div;
    logic [dsd_pkg::ACC_W-1:0] r_acc;
    logic [dsd_pkg::ACC_W-1:0] n_acc;
    logic [dsd_pkg::DIG_W-1:0] r_q;
    logic [dsd_pkg::DIG_W-1:0] n_q;

    logic [dsd_pkg::REM_W-1:0] w_base;
    logic [dsd_pkg::DIG_W-1:0] w_digit;
    logic [dsd_pkg::ACC_W-1:0] w_start;
    logic [dsd_pkg::ACC_W-1:0] w_dsh;
    logic [dsd_pkg::ACC_W:0]   w_diff;
    logic                      w_fits;

    // effective divisor: zero runs as one, oversized values saturate
    always_comb begin
        n_div = r_div;
        if (i_cfg_we) begin
            if (i_cfg_data == '0) begin
                n_div = dsd_pkg::DIV_ONE;
            end else if (i_cfg_data > dsd_pkg::DIV_MAX) begin
                n_div = dsd_pkg::DIV_MAX;
            end else begin
                n_div = i_cfg_data;
            end
        end
    end

    // remainder times ten plus the clamped digit
    assign w_base  = i_in_data.first_digit ? '0 : r_acc[dsd_pkg::REM_W-1:0];
    assign w_digit = (i_in_data.digit > dsd_pkg::DIGIT_MAX) ? dsd_pkg::DIGIT_MAX
                                                            : i_in_data.digit;
    assign w_start = dsd_pkg::ACC_W'({w_base, 3'b000})
                   + dsd_pkg::ACC_W'({w_base, 1'b0})
                   + dsd_pkg::ACC_W'(w_digit);

    // shared compare and subtract unit
    assign w_dsh  = dsd_pkg::ACC_W'(r_div) << i_ctrl.shift;
    assign w_diff = {1'b0, r_acc} - {1'b0, w_dsh};
    assign w_fits = ~w_diff[dsd_pkg::ACC_W];

    assign o_q_next   = {r_q[dsd_pkg::DIG_W-2:0], w_fits};
    assign o_rem_next = w_fits ? w_diff[dsd_pkg::REM_W-1:0] : r_acc[dsd_pkg::REM_W-1:0];

    always_comb begin
        n_acc = r_acc;
        n_q   = r_q;
        if (i_cfg_we) begin
            n_acc = '0;
        end else if (i_ctrl.load) begin
            n_acc = w_start;
            n_q   = '0;
        end else if (i_ctrl.step) begin
            n_q = o_q_next;
            if (w_fits) begin
                n_acc = w_diff[dsd_pkg::ACC_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div <= dsd_pkg::DIV_ONE;
            r_acc <= '0;
        end else begin
            r_div <= n_div;
            r_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

endmodule

### design/dsd_seq.sv
`timescale 1ns / 1ps

module dsd_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_first,
    input  logic               i_last,
    input  logic               i_cfg_we,
    input  logic               i_out_stall,
    input  logic               i_q_nz,
    output logic               o_idle,
    output dsd_pkg::t_dsd_ctrl o_ctrl,
    output logic               o_out_load,
    output logic               o_out_valid,
    output logic               o_qvalid,
    output logic               o_last
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_STEP = 1'b1;

    logic                      r_state;
    logic                      n_state;
    logic [dsd_pkg::CNT_W-1:0] r_cnt;
    logic [dsd_pkg::CNT_W-1:0] n_cnt;
    logic                      r_started;
    logic                      n_started;
    logic                      r_out_valid;
    logic                      n_out_valid;
    logic                      r_last;
    logic                      n_last;

    logic w_accept;
    logic w_out_free;
    logic w_final;

    assign o_idle     = (r_state == S_IDLE) & i_rst_n;
    assign w_accept   = o_idle & i_in_valid;
    assign w_out_free = ~r_out_valid | ~i_out_stall;
    assign w_final    = (r_state == S_STEP) && (r_cnt == '0);

    assign o_ctrl.load  = w_accept;
    assign o_ctrl.step  = (r_state == S_STEP) && ((r_cnt != '0) || w_out_free);
    assign o_ctrl.shift = r_cnt;
    assign o_out_load   = w_final & w_out_free;
    assign o_out_valid  = r_out_valid;
    assign o_qvalid     = r_started | i_q_nz;
    assign o_last       = r_last;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_started   = r_started;
        n_out_valid = r_out_valid;
        n_last      = r_last;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_cfg_we) begin
                    n_started = 1'b0;
                end else if (w_accept) begin
                    n_state = S_STEP;
                    n_cnt   = dsd_pkg::STEP_TOP;
                    n_last  = i_last;
                    if (i_first) begin
                        n_started = 1'b0;
                    end
                end
            end
            S_STEP: begin
                if (r_cnt != '0) begin
                    n_cnt = r_cnt - 1'b1;
                end else if (w_out_free) begin
                    n_state     = S_IDLE;
                    n_started   = o_qvalid;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
            r_last      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_started   <= n_started;
            r_out_valid <= n_out_valid;
            r_last      <= n_last;
        end
    end

endmodule

### design/decimal_stream_divider.sv
`timescale 1ns / 1ps

// decimal stream divider
// divides a decimal number, streamed one digit per transfer with the most
// significant digit first, by the divisor held in its one config register
// input channel: i_in_valid / o_in_stall, payload digit, first and last flags
// output channel: o_out_valid / i_out_stall, one result per input digit with
//   the quotient digit, its valid flag (low on leading zeros), the running
//   remainder and the last flag
// config channel: i_cfg_valid / o_cfg_ready, 60-bit divisor; a write clears
//   the running remainder and leading-zero state; ready only while idle
// each digit is taken while idle, forming remainder*10+digit, then runs
//   four restoring steps through the single 64-bit subtractor; the result
//   is registered on the last step, and the next digit waits until then
// the input side accepts the next digit while a result waits on the output
// register; a stalled result holds, and the last step waits for it to leave
// reset clears the state, sets the divisor to one and drops o_out_valid

module decimal_stream_divider (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  dsd_pkg::t_dsd_in          i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output dsd_pkg::t_dsd_out         o_out_data,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [dsd_pkg::DIV_W-1:0] i_cfg_data
);

    dsd_pkg::t_dsd_ctrl        w_ctrl;
    dsd_pkg::t_dsd_out         r_out;
    dsd_pkg::t_dsd_out         n_out;
    logic                      w_idle;
    logic                      w_cfg_we;
    logic                      w_out_load;
    logic                      w_qvalid;
    logic                      w_last;
    logic [dsd_pkg::DIG_W-1:0] w_q_next;
    logic [dsd_pkg::REM_W-1:0] w_rem_next;

    // a config write takes the idle cycle, the digit waits
    assign o_in_stall  = ~w_idle | w_cfg_we;
    assign o_cfg_ready = w_idle;
    assign w_cfg_we    = i_cfg_valid & w_idle;

    dsd_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_first     (i_in_data.first_digit),
        .i_last      (i_in_data.last_digit),
        .i_cfg_we    (w_cfg_we),
        .i_out_stall (i_out_stall),
        .i_q_nz      (w_q_next != '0),
        .o_idle      (w_idle),
        .o_ctrl      (w_ctrl),
        .o_out_load  (w_out_load),
        .o_out_valid (o_out_valid),
        .o_qvalid    (w_qvalid),
        .o_last      (w_last)
    );

    dsd_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_ctrl),
        .i_in_data  (i_in_data),
        .i_cfg_we   (w_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_q_next   (w_q_next),
        .o_rem_next (w_rem_next)
    );

    always_comb begin
        n_out = r_out;
        if (w_out_load) begin
            n_out.quotient_digit = w_q_next;
            n_out.quotient_valid = w_qvalid;
            n_out.remainder      = w_rem_next;
            n_out.is_last        = w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_data = r_out;

endmodule

### design/dsd_checker.sv
`timescale 1ns / 1ps

module dsd_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_stall,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input dsd_pkg::t_dsd_out         o_out_data
);

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.quotient_digit <= dsd_pkg::DIGIT_MAX))
        else $error("quotient digit above nine");

    a_suppressed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.quotient_valid) |-> (o_out_data.quotient_digit == '0))
        else $error("suppressed digit not zero");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again while busy");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

endmodule

bind decimal_stream_divider dsd_checker u_dsd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
